>>> hdl/mos_convergent_sequence_top_assert.svh
// ----------------------------------------------------------------------------
// MOS convergent sequence assertion macros
// Concurrent check wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MOS_CONVERGENT_SEQUENCE_TOP_ASSERT_SVH
`define MOS_CONVERGENT_SEQUENCE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MCS_ASSERT_SAME(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("mcs check failed");
// next-cycle implication
`define MCS_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("mcs check failed");
`else
`define MCS_ASSERT_SAME(lbl, ante, cons)
`define MCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// MOS convergent sequence package
// Shared widths, register indexes, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package mcs_pkg;

	localparam int MCS_MAX_LEVEL = 16;
	localparam int MCS_FRAC_BITS = 24;

	localparam int LEVEL_IN_W = 6;
	localparam int LEVEL_W    = 5;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_LEVEL = 1'b0,
		CFG_MAX_LEVEL = 1'b1
	} mcs_cfg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} mcs_state_t;

	// mediant coefficients
	typedef struct packed {
		logic [COEF_W-1:0] den_first;
		logic [COEF_W-1:0] den_second;
		logic [COEF_W-1:0] num_first;
		logic [COEF_W-1:0] num_second;
	} mcs_coef_t;

	// clamp a widened sum to the coefficient range
	function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W+1:0] s);
		if (s[COEF_W+1:COEF_W] != 2'b00)
			return {COEF_W{1'b1}};
		return s[COEF_W-1:0];
	endfunction

endpackage

>>> hdl/mcs_zigzag_alu.sv
// ----------------------------------------------------------------------------
// MOS convergent sequence zigzag unit
// One Brun step: weight subtract, order compare, mediant update and swap.
// ----------------------------------------------------------------------------
module mcs_zigzag_alu #(
	parameter int WGT_W = mcs_pkg::MCS_FRAC_BITS + 1
) (
	input  logic [WGT_W-1:0]              large_w,
	input  logic [WGT_W-1:0]              small_w,
	input  mcs_pkg::mcs_coef_t            coef,
	output logic [WGT_W-1:0]              large_next,
	output logic [WGT_W-1:0]              small_next,
	output mcs_pkg::mcs_coef_t            coef_next,
	output logic [mcs_pkg::COEF_W-1:0]    num_next,
	output logic [mcs_pkg::COEF_W-1:0]    den_next
);

	localparam int CW = mcs_pkg::COEF_W;

	logic [WGT_W-1:0] diff;
	logic [CW-1:0]    den_sum;
	logic [CW-1:0]    num_sum;
	logic             flip;

	always_comb begin
		// weights stay ordered, so the difference never wraps
		diff    = large_w - small_w;
		flip    = small_w > diff;
		den_sum = mcs_pkg::sat_coef({2'b00, coef.den_first} + {2'b00, coef.den_second});
		num_sum = mcs_pkg::sat_coef({2'b00, coef.num_first} + {2'b00, coef.num_second});
		// 2a+b saturated once equals the two chained saturating adds
		num_next = mcs_pkg::sat_coef({1'b0, coef.num_first, 1'b0} + {2'b00, coef.num_second});
		den_next = mcs_pkg::sat_coef({1'b0, coef.den_first, 1'b0} + {2'b00, coef.den_second});
		if (flip) begin
			large_next           = small_w;
			small_next           = diff;
			coef_next.den_first  = den_sum;
			coef_next.den_second = coef.den_first;
			coef_next.num_first  = num_sum;
			coef_next.num_second = coef.num_first;
		end else begin
			large_next           = diff;
			small_next           = small_w;
			coef_next.den_first  = coef.den_first;
			coef_next.den_second = den_sum;
			coef_next.num_first  = coef.num_first;
			coef_next.num_second = num_sum;
		end
	end

endmodule

>>> hdl/mos_convergent_sequence_top.sv
// ----------------------------------------------------------------------------
// MOS convergent sequence top level
// Brun zigzag producing the chain of convergent ratios for a generator.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one request = level + generator
//    (unsigned fixed point, FRAC_BITS fraction bits, values above 1.0 are
//    taken as 1.0). in_ready is high only while no request is in flight.
//  - The level is raised to min_level, lowered to max_level, then capped
//    at MAX_LEVEL. A request with clamped level L gives L+1 results.
//  - Output channel (out_valid/out_ready): numerator, denominator,
//    step_index and last. The first result is always 1/1; last marks
//    the final ratio of the request.
//  - Latency: first result is valid the cycle after the request is taken.
//    One zigzag step runs per accepted non-final result, and a new request
//    is taken only once the sequencer is back in idle after the last one.
//    The single zigzag unit takes one step per cycle while out_ready holds.
//  - Receiver stall: the current result holds in its registers and the
//    zigzag does not advance until out_ready is seen.
//  - Reset: arst_n clears the sequencer to idle and the registers to
//    min_level = 0, max_level = 16. Config writes (cfg_wr_en) are taken
//    any cycle and used by the next request.
// ----------------------------------------------------------------------------
`include "mos_convergent_sequence_top_assert.svh"

module mos_convergent_sequence_top #(
	parameter int MAX_LEVEL = mcs_pkg::MCS_MAX_LEVEL,
	parameter int FRAC_BITS = mcs_pkg::MCS_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mcs_pkg::LEVEL_IN_W-1:0]    level,
	input  logic [FRAC_BITS:0]                generator,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mcs_pkg::COEF_W-1:0]        numerator,
	output logic [mcs_pkg::COEF_W-1:0]        denominator,
	output logic [mcs_pkg::LEVEL_W-1:0]       step_index,
	output logic                              last
);

	localparam int WGT_W = FRAC_BITS + 1;
	localparam int LW    = mcs_pkg::LEVEL_W;
	localparam int LIW   = mcs_pkg::LEVEL_IN_W;
	localparam int CW    = mcs_pkg::COEF_W;
	localparam logic [WGT_W-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [LIW-1:0]   LVL_CAP = LIW'(MAX_LEVEL);

	// config registers
	logic [LW-1:0] min_level_q;
	logic [LW-1:0] max_level_q;

	// sequencer and working state
	mcs_pkg::mcs_state_t state_q, state_d;
	logic [LW-1:0]       lvl_q;
	logic [LW-1:0]       step_q;
	logic [WGT_W-1:0]    large_q;
	logic [WGT_W-1:0]    small_q;
	mcs_pkg::mcs_coef_t  coef_q;
	logic [CW-1:0]       num_q;
	logic [CW-1:0]       den_q;

	// zigzag unit results
	logic [WGT_W-1:0]    large_nx;
	logic [WGT_W-1:0]    small_nx;
	mcs_pkg::mcs_coef_t  coef_nx;
	logic [CW-1:0]       num_nx;
	logic [CW-1:0]       den_nx;

	logic                in_fire;
	logic                out_fire;
	logic                is_last;
	logic [LIW-1:0]      lvl_clamp;
	logic [WGT_W-1:0]    gen_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= '0;
			max_level_q <= LW'(16);
		end else if (cfg_wr_en) begin
			unique case (mcs_pkg::mcs_cfg_idx_t'(cfg_index))
				mcs_pkg::CFG_MIN_LEVEL: min_level_q <= cfg_data;
				mcs_pkg::CFG_MAX_LEVEL: max_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request clamp: min first, then max, then the hard cap
	always_comb begin
		lvl_clamp = level;
		if (lvl_clamp < {1'b0, min_level_q})
			lvl_clamp = {1'b0, min_level_q};
		if (lvl_clamp > {1'b0, max_level_q})
			lvl_clamp = {1'b0, max_level_q};
		if (lvl_clamp > LVL_CAP)
			lvl_clamp = LVL_CAP;
		gen_sat = (generator > ONE_FX) ? ONE_FX : generator;
	end

	assign in_ready  = (state_q == mcs_pkg::ST_IDLE);
	assign out_valid = (state_q == mcs_pkg::ST_RUN);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign is_last   = (step_q == lvl_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcs_pkg::ST_IDLE: begin
				if (in_fire)
					state_d = mcs_pkg::ST_RUN;
			end
			mcs_pkg::ST_RUN: begin
				if (out_fire && is_last)
					state_d = mcs_pkg::ST_IDLE;
			end
			default: state_d = mcs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mcs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	mcs_zigzag_alu #(
		.WGT_W(WGT_W)
	) u_alu (
		.large_w    (large_q),
		.small_w    (small_q),
		.coef       (coef_q),
		.large_next (large_nx),
		.small_next (small_nx),
		.coef_next  (coef_nx),
		.num_next   (num_nx),
		.den_next   (den_nx)
	);

	// working registers: seeded on request, stepped on each taken result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= '0;
			step_q  <= '0;
			large_q <= '0;
			small_q <= '0;
			coef_q  <= '0;
			num_q   <= '0;
			den_q   <= '0;
		end else if (in_fire) begin
			lvl_q             <= lvl_clamp[LW-1:0];
			step_q            <= '0;
			large_q           <= ONE_FX;
			small_q           <= gen_sat;
			coef_q.den_first  <= CW'(1);
			coef_q.den_second <= '0;
			coef_q.num_first  <= '0;
			coef_q.num_second <= CW'(1);
			num_q             <= CW'(1);
			den_q             <= CW'(1);
		end else if (out_fire && !is_last) begin
			step_q  <= step_q + LW'(1);
			large_q <= large_nx;
			small_q <= small_nx;
			coef_q  <= coef_nx;
			num_q   <= num_nx;
			den_q   <= den_nx;
		end
	end

	assign numerator   = num_q;
	assign denominator = den_q;
	assign step_index  = step_q;
	assign last        = is_last;

	// one side of the block at a time
	`MCS_ASSERT_SAME(a_busy_excl, out_valid, !in_ready)
	// run ends right after the marked result is taken
	`MCS_ASSERT_NEXT(a_last_ends, out_fire && last, !out_valid)
	// taken non-final result steps the index by one
	`MCS_ASSERT_NEXT(a_step_inc, out_fire && !last, step_index == $past(step_index) + LW'(1))
	// index never passes the clamped level
	`MCS_ASSERT_SAME(a_step_bound, out_valid, step_index <= lvl_q)

endmodule

>>> tb/sv/mcs_convergent_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MOS convergent sequence checker
// Tracks the level bounds, predicts the ratio chain of every request and
// compares each accepted ratio against the oldest expected one.
// ----------------------------------------------------------------------------
module mcs_convergent_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [mcs_pkg::LEVEL_IN_W-1:0]     level,
	input  logic [mcs_pkg::MCS_FRAC_BITS:0]    generator,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [mcs_pkg::COEF_W-1:0]         numerator,
	input  logic [mcs_pkg::COEF_W-1:0]         denominator,
	input  logic [mcs_pkg::LEVEL_W-1:0]        step_index,
	input  logic                               last,
	output int                                 mismatches,
	output int                                 ratios_pending,
	output int                                 requests_seen,
	output int                                 ratios_seen
);

	localparam int CW  = mcs_pkg::COEF_W;
	localparam int LW  = mcs_pkg::LEVEL_W;
	localparam int LIW = mcs_pkg::LEVEL_IN_W;
	localparam int FB  = mcs_pkg::MCS_FRAC_BITS;
	localparam logic [FB+1:0] ONE_FX = (FB+2)'(1) << FB;
	localparam int PRINT_CAP = 40;

	typedef struct {
		logic [CW-1:0] numerator;
		logic [CW-1:0] denominator;
		logic [LW-1:0] step_index;
		logic          last;
	} convergent_t;

	convergent_t   expected_convergents[$];
	logic [LW-1:0] min_bound;
	logic [LW-1:0] max_bound;

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic [CW-1:0] clip16(input int unsigned s);
		return (s > 65535) ? {CW{1'b1}} : CW'(s);
	endfunction

	// clamp the depth, then walk the zigzag and queue one ratio per level
	function automatic void predict_convergents(input logic [LIW-1:0] lv,
		input logic [FB:0] gen);
		int            depth;
		logic [FB+1:0] wide, narrow, swap_w;
		logic [CW-1:0] df, ds, nf, ns, num, den, swap_c;
		convergent_t   r;
		depth = int'(lv);
		if (depth < int'(min_bound))
			depth = int'(min_bound);
		if (depth > int'(max_bound))
			depth = int'(max_bound);
		if (depth > mcs_pkg::MCS_MAX_LEVEL)
			depth = mcs_pkg::MCS_MAX_LEVEL;
		wide = ONE_FX;
		narrow = (gen > ONE_FX) ? ONE_FX : gen;
		df = CW'(1); ds = '0; nf = '0; ns = CW'(1);
		num = CW'(1); den = CW'(1);
		for (int k = 0; k <= depth; k++) begin
			r.numerator = num;
			r.denominator = den;
			r.step_index = LW'(k);
			r.last = (k == depth);
			expected_convergents.insert(expected_convergents.size(), r);
			num = clip16(int'(clip16(int'(nf) + int'(nf))) + int'(ns));
			den = clip16(int'(clip16(int'(df) + int'(df))) + int'(ds));
			wide = wide - narrow;
			ds = clip16(int'(df) + int'(ds));
			ns = clip16(int'(nf) + int'(ns));
			if (narrow > wide) begin
				swap_w = wide; wide = narrow; narrow = swap_w;
				swap_c = df; df = ds; ds = swap_c;
				swap_c = nf; nf = ns; ns = swap_c;
			end
		end
	endfunction

	always @(posedge clk) begin
		convergent_t want;
		if (!arst_n) begin
			min_bound = '0;
			max_bound = LW'(mcs_pkg::MCS_MAX_LEVEL);
			expected_convergents.delete();
			mismatches = 0;
			ratios_pending = 0;
			requests_seen = 0;
			ratios_seen = 0;
		end else begin
			// a request taken on this edge still sees the old bounds
			if (in_valid && in_ready) begin
				predict_convergents(level, generator);
				requests_seen++;
			end
			if (cfg_wr_en) begin
				if (mcs_pkg::mcs_cfg_idx_t'(cfg_index) == mcs_pkg::CFG_MIN_LEVEL)
					min_bound = cfg_data;
				else if (mcs_pkg::mcs_cfg_idx_t'(cfg_index) == mcs_pkg::CFG_MAX_LEVEL)
					max_bound = cfg_data;
			end
			if (out_valid && out_ready) begin
				ratios_seen++;
				if (expected_convergents.size() == 0) begin
					report_mismatch($sformatf("unexpected ratio %0d/%0d step %0d",
						numerator, denominator, step_index));
				end else begin
					want = expected_convergents.pop_front();
					if (numerator !== want.numerator)
						report_mismatch($sformatf("numerator %0d, want %0d (step %0d)",
							numerator, want.numerator, want.step_index));
					if (denominator !== want.denominator)
						report_mismatch($sformatf("denominator %0d, want %0d (step %0d)",
							denominator, want.denominator, want.step_index));
					if (step_index !== want.step_index)
						report_mismatch($sformatf("step_index %0d, want %0d",
							step_index, want.step_index));
					if (last !== want.last)
						report_mismatch($sformatf("last %0b, want %0b (step %0d)",
							last, want.last, want.step_index));
				end
			end
			ratios_pending = expected_convergents.size();
		end
	end

endmodule

>>> tb/sv/mos_convergent_sequence_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MOS convergent sequence testbench
// Drives zigzag requests under a series of level bound settings, with bursty
// request traffic and a stalling receiver; a side checker predicts each ratio
// chain and compares it against what the block delivers.
// ----------------------------------------------------------------------------
module mos_convergent_sequence_top_tb;

	localparam int LIW = mcs_pkg::LEVEL_IN_W;
	localparam int LW  = mcs_pkg::LEVEL_W;
	localparam int CW  = mcs_pkg::COEF_W;
	localparam int FB  = mcs_pkg::MCS_FRAC_BITS;
	localparam int GW  = FB + 1;
	localparam int ML  = mcs_pkg::MCS_MAX_LEVEL;

	// 1.0 in the generator's fixed point, and the largest raw generator code
	localparam logic [GW-1:0] GEN_ONE = GW'(1) << FB;
	localparam logic [GW-1:0] GEN_TOP = {GW{1'b1}};
	// generous: every request at 17 ratios, each waiting out a long stall
	localparam int CYCLE_LIMIT = 1000000;
	// receiver hold-off: starts once this many requests went in
	localparam int HOLD_AFTER  = 150;
	localparam int HOLD_CYCLES = 400;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [mcs_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [mcs_pkg::CFG_DATA_W-1:0]   cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic [LIW-1:0]                   level;
	logic [GW-1:0]                    generator;
	logic                             out_valid;
	logic                             out_ready;
	logic [CW-1:0]                    numerator;
	logic [CW-1:0]                    denominator;
	logic [LW-1:0]                    step_index;
	logic                             last;

	int mismatches;
	int ratios_pending;
	int requests_seen;
	int ratios_seen;
	int settings_run;
	int cycle_count;

	mos_convergent_sequence_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.level       (level),
		.generator   (generator),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.numerator   (numerator),
		.denominator (denominator),
		.step_index  (step_index),
		.last        (last)
	);

	mcs_convergent_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.level          (level),
		.generator      (generator),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.numerator      (numerator),
		.denominator    (denominator),
		.step_index     (step_index),
		.last           (last),
		.mismatches     (mismatches),
		.ratios_pending (ratios_pending),
		.requests_seen  (requests_seen),
		.ratios_seen    (ratios_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[mos_convergent_sequence_top] ERROR");
			$finish;
		end
	end

	// Offer one request from a falling edge and hold it until taken.
	// Returns on the falling edge after acceptance, so the caller can chain
	// the next request without dropping valid in between.
	task automatic send_request(input logic [LIW-1:0] lv,
		input logic [GW-1:0] gen);
		in_valid <= 1'b1;
		level <= lv;
		generator <= gen;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Bounds may change only with the block idle: no request in flight, every
	// ratio delivered, and a few cycles for the sequencer to fall back to idle.
	task automatic write_level_bounds(input logic [LW-1:0] lo,
		input logic [LW-1:0] hi);
		while (ratios_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= mcs_pkg::CFG_MIN_LEVEL;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= mcs_pkg::CFG_MAX_LEVEL;
		cfg_data <= hi;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_run++;
	endtask

	// Bursts of back-to-back requests with random gaps; some gaps are zero so
	// long unbroken runs happen too. Mostly in-range generators, with a slice
	// near zero, near one, and above one (saturates to one).
	task automatic run_random(input int n);
		int              sent, burst, gap;
		logic [LIW-1:0]  lv;
		logic [GW-1:0]   gen;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && sent < n) begin
				lv = ($urandom_range(0, 3) == 0) ? LIW'($urandom_range(0, ML))
					: LIW'($urandom_range(0, 63));
				case ($urandom_range(0, 9))
					0: gen = GW'($urandom_range(GEN_ONE + 1, GEN_TOP));
					1: gen = GW'($urandom_range(0, 255));
					2: gen = GEN_ONE - GW'($urandom_range(0, 255));
					default: gen = GW'($urandom_range(0, GEN_ONE));
				endcase
				send_request(lv, gen);
				burst--;
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Receiver: switches between randomly chosen stall patterns (always ready, coin
	// flip, mostly stalled, mostly ready). Once, mid-run, it holds off for a long
	// stretch so the block backs up and the sender sits on a pending request.
	initial begin : receiver
		int  cyc, mode;
		bit  held;
		out_ready = 1'b0;
		cyc = 0;
		mode = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && requests_seen >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			cyc++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = mcs_pkg::CFG_MIN_LEVEL;
		cfg_data = '0;
		in_valid = 1'b0;
		level = '0;
		generator = '0;
		settings_run = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default bounds, directed corners
		write_level_bounds(LW'(0), LW'(ML));
		send_request(LIW'(0), GW'(0));            // single 1/1 ratio
		send_request(LIW'(63), GW'(0));           // top level, zero generator
		send_request(LIW'(63), GEN_ONE);          // generator exactly one
		send_request(LIW'(17), GEN_ONE);
		send_request(LIW'(63), GEN_TOP);          // above one, all bits set
		send_request(LIW'(16), GEN_ONE + GW'(1)); // just above one
		send_request(LIW'(16), GEN_ONE >> 1);     // half: ties the swap compare, so no swap
		send_request(LIW'(16), 25'h09E3779);      // golden section
		send_request(LIW'(16), 25'h0000001);      // smallest nonzero
		send_request(LIW'(16), GEN_ONE - GW'(1)); // just below one
		send_request(LIW'(5), 25'h0555555);       // about one third
		send_request(LIW'(1), 25'h0AAAAAA);       // about two thirds
		send_request(LIW'(2), 25'h1555555);       // above one, mixed bits
		send_request(LIW'(42), 25'h0C00000);
		send_request(LIW'(16), 25'h0400000);      // one quarter
		send_request(LIW'(7), 25'h0B504F3);       // 1/sqrt(2)
		send_request(LIW'(31), 25'h0FFFFFF);
		send_request(LIW'(16), 25'h08F5C29);
		run_random(60);

		write_level_bounds(LW'(0), LW'(0));       // every request one ratio
		run_random(25);

		write_level_bounds(LW'(ML), LW'(ML));
		run_random(40);

		write_level_bounds(LW'(5), LW'(10));
		run_random(60);

		// crossed bounds: the upper bound wins
		write_level_bounds(LW'(12), LW'(3));
		send_request(LIW'(0), 25'h09E3779);
		send_request(LIW'(63), 25'h0555555);
		run_random(40);

		// upper bound past the block's depth: capped at MAX_LEVEL
		write_level_bounds(LW'(0), LW'(31));
		send_request(LIW'(63), 25'h09E3779);
		send_request(LIW'(20), GEN_TOP);
		run_random(60);

		write_level_bounds(LW'(31), LW'(31));
		run_random(25);

		repeat (4) begin
			write_level_bounds(LW'($urandom_range(0, 31)), LW'($urandom_range(0, 31)));
			run_random(20);
		end

		// drain, then give the block time to show any stray ratio
		while (ratios_pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d requests, %0d ratios over %0d bound settings",
			requests_seen, ratios_seen, settings_run);
		$display("bounds included zero, crossed, and past the depth cap");
		if (mismatches == 0 && ratios_pending == 0)
			$display("[mos_convergent_sequence_top] OK");
		else
			$display("[mos_convergent_sequence_top] ERROR");
		$finish;
	end

endmodule
